// ===== rtl/rfp_pkg.sv =====
package rfp_pkg;

    // frame layout
    localparam int TARGETS_DEF = 3;
    localparam int HDR_LEN     = 4;
    localparam int TGT_LEN     = 8;
    localparam int TRL_LEN     = 2;

    // valid target count, wide enough for the largest slot count
    localparam int COUNT_W     = 4;

    localparam logic [7:0] HDR_B0 = 8'hAA;
    localparam logic [7:0] HDR_B1 = 8'hFF;
    localparam logic [7:0] HDR_B2 = 8'h03;
    localparam logic [7:0] HDR_B3 = 8'h00;
    localparam logic [7:0] TRL_B0 = 8'h55;
    localparam logic [7:0] TRL_B1 = 8'hCC;

    localparam logic [15:0] SIGN_BIT = 16'h8000;
    localparam logic [15:0] MAG_MASK = 16'h7FFF;

    // completed frame waiting to be decoded
    typedef struct packed {
        logic        done;
        logic [31:0] time_ms;
    } frame_evt_t;

    // one decoded target slot
    typedef struct packed {
        logic               valid;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] speed_cm_s;
        logic [15:0]        dist_res;
    } target_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = HDR_B0;
            2'd1:    b = HDR_B1;
            2'd2:    b = HDR_B2;
            default: b = HDR_B3;
        endcase
        return b;
    endfunction

    // sign-magnitude with bit 15 set meaning positive
    function automatic logic [15:0] sm_decode(input logic [15:0] raw);
        logic [15:0] mag;
        mag = raw & MAG_MASK;
        if ((raw & SIGN_BIT) != 16'h0000)
            return mag;
        else
            return 16'(16'h0000 - mag);
    endfunction

endpackage

// ===== rtl/rfp_capture.sv =====
module rfp_capture #(
    parameter int TARGETS = rfp_pkg::TARGETS_DEF,
    localparam int LINE_LEN = TARGETS * rfp_pkg::TGT_LEN + rfp_pkg::TRL_LEN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         time_ms,
    input  logic                take,
    output rfp_pkg::frame_evt_t evt,
    output logic [7:0]          line [LINE_LEN]
);
    import rfp_pkg::*;

    localparam int FRAME_LEN = HDR_LEN + TARGETS * TGT_LEN + TRL_LEN;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] HDR_END  = POS_W'(HDR_LEN);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             done_reg, done_next;
    logic [31:0]      time_reg;
    logic [7:0]       line_reg [LINE_LEN];
    logic             accept;
    logic             frame_end;

    assign in_ready  = !done_reg || take;
    assign accept    = in_valid && in_ready;
    assign frame_end = (pos_reg == LAST_POS);

    // header alignment and position count
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            priority if (pos_reg < HDR_END)
            begin
                if (rx_byte != hdr_byte(pos_reg[1:0]))
                    pos_next = (pos_reg != '0 && rx_byte == HDR_B0) ? POS_W'(1) : '0;
                else
                    pos_next = pos_reg + POS_W'(1);
            end
            else if (frame_end)
                pos_next = '0;
            else
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        priority if (accept && frame_end)
            done_next = 1'b1;
        else if (take)
            done_next = 1'b0;
        else
            done_next = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    // the last bytes received sit on the line, newest at index 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg[0] <= rx_byte;
            for (int i = 1; i < LINE_LEN; i++)
                line_reg[i] <= line_reg[i-1];
            if (frame_end)
                time_reg <= time_ms;
        end
    end

    assign evt.done    = done_reg;
    assign evt.time_ms = time_reg;
    assign line        = line_reg;

endmodule

// ===== rtl/rfp_decode.sv =====
module rfp_decode #(
    parameter int TARGETS = rfp_pkg::TARGETS_DEF,
    localparam int LINE_LEN = TARGETS * rfp_pkg::TGT_LEN + rfp_pkg::TRL_LEN
) (
    input  logic [7:0]                     line [LINE_LEN],
    output rfp_pkg::target_t               targets [TARGETS],
    output logic                           trailer_ok,
    output logic [rfp_pkg::COUNT_W-1:0]    valid_count
);
    import rfp_pkg::*;

    logic [TARGETS-1:0] slot_valid;

    assign trailer_ok = (line[1] == TRL_B0) && (line[0] == TRL_B1);

    for (genvar k = 0; k < TARGETS; k++)
    begin : g_slot
        // low byte of each word, counted back from the newest byte
        localparam int LO_X = LINE_LEN - 1 - k * TGT_LEN;
        localparam int LO_Y = LO_X - 2;
        localparam int LO_S = LO_X - 4;
        localparam int LO_R = LO_X - 6;

        logic [15:0] wx, wy, ws, wr;
        logic        nz;

        assign wx = {line[LO_X-1], line[LO_X]};
        assign wy = {line[LO_Y-1], line[LO_Y]};
        assign ws = {line[LO_S-1], line[LO_S]};
        assign wr = {line[LO_R-1], line[LO_R]};
        assign nz = (wx | wy | ws | wr) != 16'h0000;

        assign slot_valid[k]         = nz;
        assign targets[k].valid      = nz;
        assign targets[k].x_mm       = nz ? sm_decode(wx) : 16'sh0000;
        assign targets[k].y_mm       = nz ? sm_decode(wy) : 16'sh0000;
        assign targets[k].speed_cm_s = nz ? sm_decode(ws) : 16'sh0000;
        assign targets[k].dist_res   = nz ? wr : 16'h0000;
    end

    always_comb
    begin
        valid_count = '0;
        for (int k = 0; k < TARGETS; k++)
            valid_count = valid_count + COUNT_W'(slot_valid[k]);
    end

endmodule

// ===== rtl/rfp_burst.sv =====
module rfp_burst #(
    parameter int TARGETS = rfp_pkg::TARGETS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rfp_pkg::frame_evt_t         evt,
    input  rfp_pkg::target_t            targets [TARGETS],
    input  logic                        trailer_ok,
    input  logic [rfp_pkg::COUNT_W-1:0] valid_count,
    output logic                        take,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        frame_good,
    output logic [1:0]                  target_index,
    output logic                        target_valid,
    output logic signed [15:0]          x_mm,
    output logic signed [15:0]          y_mm,
    output logic signed [15:0]          speed_cm_s,
    output logic [15:0]                 dist_res,
    output logic [1:0]                  valid_count_out,
    output logic [31:0]                 frame_time_ms,
    output logic [31:0]                 good_frames,
    output logic [31:0]                 bad_frames,
    output logic                        last
);
    import rfp_pkg::*;

    localparam int IDX_W = (TARGETS > 1) ? $clog2(TARGETS) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TARGETS - 1);

    // burst buffer
    logic               busy_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic               good_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [31:0]        time_reg;
    target_t            tgt_reg [TARGETS];
    logic [31:0]        good_cnt_reg;
    logic [31:0]        bad_cnt_reg;

    // result register
    logic               out_valid_reg;
    logic               frame_good_reg;
    logic [1:0]         target_index_reg;
    logic               target_valid_reg;
    logic signed [15:0] x_mm_reg;
    logic signed [15:0] y_mm_reg;
    logic signed [15:0] speed_reg;
    logic [15:0]        res_reg;
    logic [1:0]         count_out_reg;
    logic [31:0]        time_out_reg;
    logic [31:0]        good_out_reg;
    logic [31:0]        bad_out_reg;
    logic               last_reg;

    logic    load_out;
    logic    out_last;
    logic    burst_free;
    target_t sel;

    assign load_out   = busy_reg && (!out_valid_reg || out_ready);
    assign out_last   = (idx_reg == last_idx_reg);
    assign burst_free = !busy_reg || (load_out && out_last);
    assign take       = evt.done && burst_free;
    assign sel        = tgt_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            good_cnt_reg  <= '0;
            bad_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (take)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (load_out)
            begin
                if (out_last)
                    busy_reg <= 1'b0;
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (take)
            begin
                if (trailer_ok)
                    good_cnt_reg <= good_cnt_reg + 32'd1;
                else
                    bad_cnt_reg <= bad_cnt_reg + 32'd1;
            end

            priority if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tgt_reg      <= targets;
            good_reg     <= trailer_ok;
            count_reg    <= trailer_ok ? valid_count : '0;
            time_reg     <= evt.time_ms;
            last_idx_reg <= trailer_ok ? LAST_SLOT : '0;
        end

        if (load_out)
        begin
            frame_good_reg   <= good_reg;
            target_index_reg <= 2'(idx_reg);
            target_valid_reg <= good_reg && sel.valid;
            x_mm_reg         <= good_reg ? sel.x_mm : 16'sh0000;
            y_mm_reg         <= good_reg ? sel.y_mm : 16'sh0000;
            speed_reg        <= good_reg ? sel.speed_cm_s : 16'sh0000;
            res_reg          <= good_reg ? sel.dist_res : 16'h0000;
            count_out_reg    <= 2'(count_reg);
            time_out_reg     <= time_reg;
            good_out_reg     <= good_cnt_reg;
            bad_out_reg      <= bad_cnt_reg;
            last_reg         <= out_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_good      = frame_good_reg;
    assign target_index    = target_index_reg;
    assign target_valid    = target_valid_reg;
    assign x_mm            = x_mm_reg;
    assign y_mm            = y_mm_reg;
    assign speed_cm_s      = speed_reg;
    assign dist_res        = res_reg;
    assign valid_count_out = count_out_reg;
    assign frame_time_ms   = time_out_reg;
    assign good_frames     = good_out_reg;
    assign bad_frames      = bad_out_reg;
    assign last            = last_reg;

endmodule

// ===== rtl/radar_target_frame_parser_top.sv =====
// radar target frame parser
//
// input channel: one serial byte (rx_byte) with its arrival time (time_ms) per
// transfer on in_valid / in_ready. the parser aligns on header AA FF 03 00,
// collects a frame of 4 + 8*TARGETS + 2 bytes and checks trailer 55 CC.
// output channel: out_valid / out_ready. a good frame gives TARGETS results,
// one per target slot, the final one with last set; a bad trailer gives one
// error result with frame_good low. good and bad frame counts wrap at 32 bits.
//
// the frame's final byte sets the done flag, the burst buffer then takes the
// frame and the result register shows the first result; after that, one result
// per cycle while out_ready is high. throughput: one byte per cycle; the only
// wait is at a frame end, where a new byte is refused while the previous burst
// still holds the burst buffer. the single-port result register drains the
// burst buffer one slot a cycle while the receiver is ready. when it stalls,
// the result register and the burst buffer hold; the input keeps taking bytes
// until the next frame end needs the buffer. reset clears the header position,
// the frame counts and the done, busy and output valid flags.
module radar_target_frame_parser_top #(
    parameter int TARGETS = rfp_pkg::TARGETS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic [31:0]        time_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               frame_good,
    output logic [1:0]         target_index,
    output logic               target_valid,
    output logic signed [15:0] x_mm,
    output logic signed [15:0] y_mm,
    output logic signed [15:0] speed_cm_s,
    output logic [15:0]        dist_res,
    output logic [1:0]         valid_count,
    output logic [31:0]        frame_time_ms,
    output logic [31:0]        good_frames,
    output logic [31:0]        bad_frames,
    output logic               last
);
    import rfp_pkg::*;

    localparam int LINE_LEN = TARGETS * TGT_LEN + TRL_LEN;

    frame_evt_t         evt;
    logic               take;
    logic [7:0]         line [LINE_LEN];
    target_t            targets [TARGETS];
    logic               trailer_ok;
    logic [COUNT_W-1:0] slot_count;

    // byte alignment, position count and the byte line of the current frame
    rfp_capture #(
        .TARGETS (TARGETS)
    ) u_capture (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .time_ms  (time_ms),
        .take     (take),
        .evt      (evt),
        .line     (line)
    );

    // trailer check and per-slot sign-magnitude decode
    rfp_decode #(
        .TARGETS (TARGETS)
    ) u_decode (
        .line        (line),
        .targets     (targets),
        .trailer_ok  (trailer_ok),
        .valid_count (slot_count)
    );

    // burst buffer, frame counters and result register
    rfp_burst #(
        .TARGETS (TARGETS)
    ) u_burst (
        .clk             (clk),
        .rst_n           (rst_n),
        .evt             (evt),
        .targets         (targets),
        .trailer_ok      (trailer_ok),
        .valid_count     (slot_count),
        .take            (take),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_good      (frame_good),
        .target_index    (target_index),
        .target_valid    (target_valid),
        .x_mm            (x_mm),
        .y_mm            (y_mm),
        .speed_cm_s      (speed_cm_s),
        .dist_res        (dist_res),
        .valid_count_out (valid_count),
        .frame_time_ms   (frame_time_ms),
        .good_frames     (good_frames),
        .bad_frames      (bad_frames),
        .last            (last)
    );

endmodule

// ===== rtl/rfp_checker.sv =====
module rfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               frame_good,
    input logic [1:0]         target_index,
    input logic               target_valid,
    input logic signed [15:0] x_mm,
    input logic signed [15:0] y_mm,
    input logic signed [15:0] speed_cm_s,
    input logic [15:0]        dist_res,
    input logic [1:0]         valid_count,
    input logic [31:0]        good_frames,
    input logic               last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_mm) && $stable(last)
            && $stable(good_frames))
        else $error("result changed while stalled");

    // a rejected frame is one lone error result
    a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_good |-> last && target_index == 2'd0 && valid_count == 2'd0)
        else $error("bad frame result malformed");

    // an invalid slot carries zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !target_valid |-> x_mm == 16'sh0000 && y_mm == 16'sh0000
            && speed_cm_s == 16'sh0000 && dist_res == 16'h0000)
        else $error("invalid target with nonzero fields");

    // a burst runs without gaps and within one frame
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && frame_good
            && good_frames == $past(good_frames))
        else $error("burst broken");

endmodule

bind radar_target_frame_parser_top rfp_checker u_rfp_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// byte-stream check of the radar target frame parser
module testbench;
    import rfp_pkg::*;

    // frame geometry, taken from the package
    localparam int SLOTS       = TARGETS_DEF;
    localparam int WORDS       = SLOTS * 4;
    localparam int FRAME_BYTES = HDR_LEN + SLOTS * TGT_LEN + TRL_LEN;

    // run control
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 250;
    localparam int SETTLE      = 8;

    // header sequence indexed by position, in arrival order
    localparam logic [0:HDR_LEN-1][7:0] HEADER = {HDR_B0, HDR_B1, HDR_B2, HDR_B3};
    localparam logic [15:0] GOOD_TRAILER = {TRL_B0, TRL_B1};

    // four words per slot in the order x, y, speed, resolution
    typedef logic [0:WORDS-1][15:0] frame_words_t;

    // one decoded target report, field order matches the output ports
    typedef struct packed {
        logic        frame_good;
        logic [1:0]  index;
        logic        tvalid;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] speed;
        logic [15:0] res;
        logic [1:0]  vcount;
        logic [31:0] stamp;
        logic [31:0] goods;
        logic [31:0] bads;
        logic        last_flag;
    } target_report_t;

    // ------------------------------------------------------------------
    // clock, reset and dut ports
    // ------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         rx_byte   = 8'h00;
    logic [31:0]        time_ms   = 32'h0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic               frame_good;
    logic [1:0]         target_index;
    logic               target_valid;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] speed_cm_s;
    logic [15:0]        dist_res;
    logic [1:0]         valid_count;
    logic [31:0]        frame_time_ms;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;
    logic               last;

    initial
    begin
        forever #5 clk = ~clk;
    end

    radar_target_frame_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .time_ms       (time_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_good    (frame_good),
        .target_index  (target_index),
        .target_valid  (target_valid),
        .x_mm          (x_mm),
        .y_mm          (y_mm),
        .speed_cm_s    (speed_cm_s),
        .dist_res      (dist_res),
        .valid_count   (valid_count),
        .frame_time_ms (frame_time_ms),
        .good_frames   (good_frames),
        .bad_frames    (bad_frames),
        .last          (last)
    );

    // ------------------------------------------------------------------
    // shared run state
    // ------------------------------------------------------------------
    int errors         = 0;
    int cycles         = 0;
    int send_idle_pct  = 0;   // chance per byte slot that the sender stays idle
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int hold_trigger   = 0;   // bumped by a test to start a long receiver hold
    int hold_seen      = 0;
    int hold_left      = 0;   // owned by the receiver process

    // parser shadow: alignment position, frame bytes and frame counters
    logic [4:0]     sync_pos = 5'd0;
    logic [7:0]     frame_bytes [FRAME_BYTES];
    logic [31:0]    good_total = 32'h0;
    logic [31:0]    bad_total  = 32'h0;
    target_report_t pending_targets [$];

    // ------------------------------------------------------------------
    // decode helpers
    // ------------------------------------------------------------------

    // bit 15 set means positive, magnitude in bits 14..0
    function automatic logic [15:0] sign_mag(input logic [15:0] raw);
        logic [15:0] mag;
        mag = {1'b0, raw[14:0]};
        return raw[15] ? mag : 16'(-mag);
    endfunction

    // advance the parser shadow by one accepted byte and queue the reports
    // that a completed frame produces
    task automatic track_radar_byte(input logic [7:0] b, input logic [31:0] stamp);
        int             p;
        int             k;
        int             base;
        int             hits;
        logic [15:0]    wx;
        logic [15:0]    wy;
        logic [15:0]    ws;
        logic [15:0]    wr;
        target_report_t slot_reports [SLOTS];
        target_report_t rejected;
        p = int'(sync_pos);
        if (p >= FRAME_BYTES)
            p = 0;
        frame_bytes[p] = b;
        if (p < HDR_LEN)
        begin
            // header: a mismatching AA past the first position is itself a new start
            if (b == HEADER[p])
                sync_pos = 5'(p + 1);
            else if (p != 0 && b == HDR_B0)
                sync_pos = 5'd1;
            else
                sync_pos = 5'd0;
        end
        else if (p + 1 < FRAME_BYTES)
        begin
            sync_pos = 5'(p + 1);
        end
        else
        begin
            sync_pos = 5'd0;
            if ({frame_bytes[FRAME_BYTES-2], frame_bytes[FRAME_BYTES-1]} == GOOD_TRAILER)
            begin
                good_total = good_total + 32'd1;
                hits = 0;
                for (k = 0; k < SLOTS; k++)
                begin
                    base = HDR_LEN + k * TGT_LEN;
                    wx = {frame_bytes[base+1], frame_bytes[base]};
                    wy = {frame_bytes[base+3], frame_bytes[base+2]};
                    ws = {frame_bytes[base+5], frame_bytes[base+4]};
                    wr = {frame_bytes[base+7], frame_bytes[base+6]};
                    slot_reports[k] = '0;
                    slot_reports[k].frame_good = 1'b1;
                    slot_reports[k].index = 2'(k);
                    // an all-zero slot is empty and reports zero fields
                    slot_reports[k].tvalid = |{wx, wy, ws, wr};
                    if (slot_reports[k].tvalid)
                    begin
                        slot_reports[k].x = sign_mag(wx);
                        slot_reports[k].y = sign_mag(wy);
                        slot_reports[k].speed = sign_mag(ws);
                        slot_reports[k].res = wr;
                        hits++;
                    end
                end
                // frame-wide fields are known only once every slot is decoded
                for (k = 0; k < SLOTS; k++)
                begin
                    slot_reports[k].vcount = 2'(hits);
                    slot_reports[k].stamp = stamp;
                    slot_reports[k].goods = good_total;
                    slot_reports[k].bads = bad_total;
                    slot_reports[k].last_flag = (k == SLOTS - 1);
                    pending_targets.push_back(slot_reports[k]);
                end
            end
            else
            begin
                // bad trailer: a single error report, counters filled as usual
                bad_total = bad_total + 32'd1;
                rejected = '0;
                rejected.stamp = stamp;
                rejected.goods = good_total;
                rejected.bads = bad_total;
                rejected.last_flag = 1'b1;
                pending_targets.push_back(rejected);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // one byte transfer; entered and left right after a rising edge
    task automatic send_byte(input logic [7:0] b, input logic [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom());
            time_ms  <= $urandom();
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        time_ms  <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_radar_byte(b, stamp);
    endtask

    // a complete frame; end_stamp goes with the byte that closes it
    task automatic send_frame(input frame_words_t words, input logic [15:0] trailer,
                              input logic [31:0] end_stamp);
        int i;
        for (i = 0; i < HDR_LEN; i++)
            send_byte(HEADER[i], $urandom());
        // words go out little-endian
        for (i = 0; i < WORDS; i++)
        begin
            send_byte(words[i][7:0], $urandom());
            send_byte(words[i][15:8], $urandom());
        end
        send_byte(trailer[15:8], $urandom());
        send_byte(trailer[7:0], end_stamp);
    endtask

    // stray bytes between frames: either a lone non-AA byte or a header
    // that breaks off after one to three bytes; both leave the parser in the
    // header so the next frame still aligns
    task automatic send_noise();
        int         depth;
        int         i;
        logic [7:0] b;
        if ($urandom_range(1) == 0)
        begin
            b = 8'($urandom());
            while (b == HDR_B0)
                b = 8'($urandom());
            send_byte(b, $urandom());
        end
        else
        begin
            depth = $urandom_range(HDR_LEN - 2, 0);
            for (i = 0; i <= depth; i++)
                send_byte(HEADER[i], $urandom());
            b = 8'($urandom());
            while (b == HEADER[depth+1])
                b = 8'($urandom());
            send_byte(b, $urandom());
        end
    endtask

    // bias toward the sign-magnitude corner words
    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return SIGN_BIT;
            2:       return MAG_MASK;
            3:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // well-formed frame with random content, sometimes a broken trailer,
    // sometimes preceded by stray bytes
    task automatic send_random_frame();
        frame_words_t words;
        logic [15:0]  trailer;
        int           k;
        int           w;
        while ($urandom_range(9) < 3)
            send_noise();
        for (k = 0; k < SLOTS; k++)
        begin
            for (w = 0; w < 4; w++)
                words[k*4+w] = ($urandom_range(4) == 0) ? 16'h0000 : pick_word();
        end
        trailer = GOOD_TRAILER;
        if ($urandom_range(99) < 15)
        begin
            trailer = 16'($urandom());
            if (trailer == GOOD_TRAILER)
                trailer[0] = ~trailer[0];
        end
        send_frame(words, trailer, $urandom());
    endtask

    // let the result burst drain, then settle; in_valid drops right after
    // the last transfer so no byte is taken twice
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_targets.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // header mismatches at every position, with and without an AA restart
    task automatic test_header_resync();
        logic [7:0] prefix [15];
        int         i;
        prefix = '{8'h00, 8'h55, 8'hAA, 8'hAA, 8'h12, 8'hAA, 8'hFF, 8'hAA,
                   8'hFF, 8'h03, 8'h01, 8'hAA, 8'hFF, 8'h03, 8'hAA};
        for (i = 0; i < 15; i++)
            send_byte(prefix[i], $urandom());
        // parser now sits after a lone AA; the next header must still align
        send_frame({16'h8123, 16'h0456, 16'h8789, 16'h0ABC,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h1111, 16'h9222, 16'h0333, 16'h4444},
                   GOOD_TRAILER, 32'h1234_5678);
        wait_drain();
    endtask

    // field extremes, negative zero, empty slots and valid counts of zero, two and three
    task automatic test_target_decode();
        // full-scale magnitudes of both signs, positive zero, empty third slot
        send_frame({16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF,
                    16'h0000, 16'h0001, 16'h8001, 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000},
                   GOOD_TRAILER, 32'hFFFF_FFFF);
        // every slot empty
        send_frame('0, GOOD_TRAILER, 32'h0000_0000);
        // every slot valid, some on a single nonzero word
        send_frame({16'h0000, 16'h0000, 16'h0000, 16'h0001,
                    16'h8000, 16'h0000, 16'h0000, 16'h0000,
                    16'h5A5A, 16'hA5A5, 16'h1234, 16'hCDEF},
                   GOOD_TRAILER, $urandom());
        wait_drain();
    endtask

    // each trailer byte wrong on its own
    task automatic test_bad_trailer();
        send_frame({WORDS{16'h8001}}, {TRL_B0, 8'hCD}, 32'hFFFF_FFFF);
        send_frame({WORDS{16'h7FFE}}, {8'h54, TRL_B1}, 32'h0000_0000);
        wait_drain();
    endtask

    // one random frame under each idling mix
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            send_random_frame();
            wait_drain();
        end
    endtask

    // receiver holds off while frames keep arriving, so the burst buffer
    // fills and the stray bytes after the second frame get refused
    task automatic test_backpressure();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_trigger++;
        for (n = 0; n < 2; n++)
            send_random_frame();
        send_noise();
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus the long hold requested by a test
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // result checker: every transfer against the oldest queued report
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        target_report_t want;
        target_report_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {frame_good, target_index, target_valid, x_mm, y_mm, speed_cm_s,
                   dist_res, valid_count, frame_time_ms, good_frames,
                   bad_frames, last};
            if (pending_targets.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, index %0d frame_good %0b",
                         $time, target_index, frame_good);
            end
            else
            begin
                want = pending_targets.pop_front();
                check_field("frame_good", want.frame_good, got.frame_good);
                check_field("target_index", want.index, got.index);
                check_field("target_valid", want.tvalid, got.tvalid);
                check_field("x_mm", want.x, got.x);
                check_field("y_mm", want.y, got.y);
                check_field("speed_cm_s", want.speed, got.speed);
                check_field("dist_res", want.res, got.res);
                check_field("valid_count", want.vcount, got.vcount);
                check_field("frame_time_ms", want.stamp, got.stamp);
                check_field("good_frames", want.goods, got.goods);
                check_field("bad_frames", want.bads, got.bads);
                check_field("last", want.last_flag, got.last_flag);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_resync();
        test_target_decode();
        test_bad_trailer();
        test_random_traffic();
        test_backpressure();
        // reports still queued here count as failures
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending_targets.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
